[hdl/u2u_pkg.sv]
// Shared types and constants for the UTF-8 to UCS-2 decoder.
package u2u_pkg;

    // Lead tracking between input items.
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,   // no lead held
        PH_TWO    = 2'd1,   // two-byte lead held
        PH_THREE  = 2'd2,   // three-byte lead held
        PH_THREE2 = 2'd3    // three-byte lead and one continuation held
    } phase_t;

    localparam int unsigned PARTIAL_W  = 10;
    localparam logic [15:0] QMARK      = 16'h003F;

    // Result queue geometry.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    // One result item.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        substituted;
        logic        run_last;
        logic        text_last;
    } result_t;

    // Everything the decoder produces for one input item.
    typedef struct packed {
        logic [1:0]             n_units;
        result_t                unit0;
        result_t                unit1;
        phase_t                 phase;
        logic [PARTIAL_W-1:0]   partial;
    } dec_out_t;

endpackage

[hdl/u2u_decode.sv]
// Combinational decode of one UTF-8 byte against the held lead state.
module u2u_decode (
    input  logic [7:0]                       byte_in,
    input  logic                             text_end,
    input  u2u_pkg::phase_t                  phase,
    input  logic [u2u_pkg::PARTIAL_W-1:0]    partial,
    output u2u_pkg::dec_out_t                dec
);

    logic is_ascii;
    logic is_lead2;
    logic is_lead3;

    assign is_ascii = ~byte_in[7];
    assign is_lead2 = (byte_in[7:5] == 3'b110);
    assign is_lead3 = (byte_in[7:4] == 4'b1110);

    always_comb begin
        dec         = '0;
        dec.phase   = phase;
        dec.partial = partial;

        unique case (phase)
            u2u_pkg::PH_IDLE: begin
                if (is_ascii) begin
                    dec.unit0.code_unit = {8'h00, byte_in};
                    dec.n_units         = 2'd1;
                end else if (is_lead2 && !text_end) begin
                    dec.phase   = u2u_pkg::PH_TWO;
                    dec.partial = {5'b0, byte_in[4:0]};
                end else if (is_lead3 && !text_end) begin
                    dec.phase   = u2u_pkg::PH_THREE;
                    dec.partial = {6'b0, byte_in[3:0]};
                end else begin
                    dec.unit0.code_unit   = u2u_pkg::QMARK;
                    dec.unit0.substituted = 1'b1;
                    dec.n_units           = 2'd1;
                end
            end
            u2u_pkg::PH_TWO: begin
                dec.unit0.code_unit = {5'b0, partial[4:0], byte_in[5:0]};
                dec.n_units         = 2'd1;
                dec.phase           = u2u_pkg::PH_IDLE;
                dec.partial         = '0;
            end
            u2u_pkg::PH_THREE: begin
                if (text_end) begin
                    // Cut-off lead becomes '?', then the byte is decoded on its own.
                    dec.unit0.code_unit   = u2u_pkg::QMARK;
                    dec.unit0.substituted = 1'b1;
                    if (is_ascii) begin
                        dec.unit1.code_unit = {8'h00, byte_in};
                    end else begin
                        dec.unit1.code_unit   = u2u_pkg::QMARK;
                        dec.unit1.substituted = 1'b1;
                    end
                    dec.n_units = 2'd2;
                    dec.phase   = u2u_pkg::PH_IDLE;
                    dec.partial = '0;
                end else begin
                    dec.partial = {partial[3:0], byte_in[5:0]};
                    dec.phase   = u2u_pkg::PH_THREE2;
                end
            end
            u2u_pkg::PH_THREE2: begin
                dec.unit0.code_unit = {partial, byte_in[5:0]};
                dec.n_units         = 2'd1;
                dec.phase           = u2u_pkg::PH_IDLE;
                dec.partial         = '0;
            end
        endcase

        if (text_end) begin
            dec.phase   = u2u_pkg::PH_IDLE;
            dec.partial = '0;
        end

        if (dec.n_units == 2'd1) begin
            dec.unit0.run_last  = 1'b1;
            dec.unit0.text_last = text_end;
        end else if (dec.n_units == 2'd2) begin
            dec.unit1.run_last  = 1'b1;
            dec.unit1.text_last = text_end;
        end
    end

endmodule

[hdl/utf8_to_ucs2_decoder.sv]
// Top level of the UTF-8 to UCS-2 decoder: lead state, decode and result queue.
//
//  Channel  Dir  Payload                                    Marker / flags
//  -------  ---  -----------------------------------------  --------------------------------
//  s_       in   tdata[7:0] = byte_in                       tlast = text_end
//  m_       out  tdata[15:0] = code_unit                    tuser = {run_last, substituted},
//                                                           tlast = text_last
//
// Each input byte is decoded in the cycle it is accepted; its zero, one or two
// result items land in a four-entry result queue and appear on the m_ side
// from the next cycle on. The block accepts one byte per cycle while the queue
// holds at most two items, so with m_tready high a stream of single-result bytes
// runs at one item per cycle; the two results of one byte leave one at a time.
// Reset clears the held lead and empties the queue. s_tready depends only on
// registered queue occupancy, so a stalled m_ side never reaches the input
// combinationally.
module utf8_to_ucs2_decoder (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] byte_in
    input  logic        s_tlast,

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [15:0] code_unit
    output logic [1:0]  m_tuser,     // [0] substituted, [1] run_last
    output logic        m_tlast
);

    // Held lead: which kind of multi-byte sequence is open and its bits so far.
    u2u_pkg::phase_t                   phase_reg, phase_next;
    logic [u2u_pkg::PARTIAL_W-1:0]     partial_reg, partial_next;

    // Result queue. Up to two entries are written per cycle, one is read.
    u2u_pkg::result_t                  queue_reg [u2u_pkg::FIFO_DEPTH];
    logic [u2u_pkg::PTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [u2u_pkg::PTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [u2u_pkg::CNT_W-1:0]         count_reg, count_next;

    u2u_pkg::dec_out_t                 dec;
    u2u_pkg::result_t                  head;
    logic                              s_fire;
    logic                              m_fire;
    logic [u2u_pkg::PTR_W-1:0]         wr_ptr_plus1;

    u2u_decode u_decode (
        .byte_in  (s_tdata),
        .text_end (s_tlast),
        .phase    (phase_reg),
        .partial  (partial_reg),
        .dec      (dec)
    );

    // Room for a worst-case two-result byte keeps the input open.
    assign s_tready = (count_reg <= u2u_pkg::CNT_W'(u2u_pkg::FIFO_DEPTH - 2));
    assign s_fire   = s_tvalid && s_tready;

    assign head     = queue_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_fire   = m_tvalid && m_tready;
    assign m_tdata  = head.code_unit;
    assign m_tuser  = {head.run_last, head.substituted};
    assign m_tlast  = head.text_last;

    assign wr_ptr_plus1 = wr_ptr_reg + u2u_pkg::PTR_W'(1);

    always_comb begin
        phase_next   = phase_reg;
        partial_next = partial_reg;
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        count_next   = count_reg;

        if (s_fire) begin
            phase_next   = dec.phase;
            partial_next = dec.partial;
            wr_ptr_next  = wr_ptr_reg + u2u_pkg::PTR_W'(dec.n_units);
            count_next   = count_next + u2u_pkg::CNT_W'(dec.n_units);
        end
        if (m_fire) begin
            rd_ptr_next = rd_ptr_reg + u2u_pkg::PTR_W'(1);
            count_next  = count_next - u2u_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= u2u_pkg::PH_IDLE;
            partial_reg <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end else begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
        end
    end

    // Queue payload needs no reset; occupancy says which entries are live.
    always_ff @(posedge aclk) begin
        if (s_fire && (dec.n_units != 2'd0)) begin
            queue_reg[wr_ptr_reg] <= dec.unit0;
        end
        if (s_fire && (dec.n_units == 2'd2)) begin
            queue_reg[wr_ptr_plus1] <= dec.unit1;
        end
    end

    // The queue never overfills.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= u2u_pkg::CNT_W'(u2u_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // The end of a text always leaves the decoder with no lead held.
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (phase_reg == u2u_pkg::PH_IDLE && partial_reg == '0))
        else $error("lead state survived end of text");

    // The end of a text always yields at least one queued result.
    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (count_reg != '0))
        else $error("end of text produced no result");

    // The final unit of a text is also the last result of its byte.
    a_last_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[1])
        else $error("text_last without run_last");

endmodule

[tb/ucs2_unit_checker.sv]
// Checker for the UTF-8 to UCS-2 decoder: predicts code units from accepted bytes and compares.
module ucs2_unit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          failures,
    output int          outstanding
);

    // Our own copy of the lead state.
    u2u_pkg::phase_t                 held_phase;
    logic [u2u_pkg::PARTIAL_W-1:0]   held_bits;

    u2u_pkg::result_t expected_units[$];
    u2u_pkg::result_t new_units[2];

    function automatic u2u_pkg::result_t make_unit(input logic [15:0] code, input logic sub);
        u2u_pkg::result_t r;
        r.code_unit   = code;
        r.substituted = sub;
        r.run_last    = 1'b0;
        r.text_last   = 1'b0;
        return r;
    endfunction

    // Decode a byte with no lead held: a unit of its own, a held lead, or a '?'.
    task automatic open_byte(input logic [7:0] b, input logic fin, inout int n);
        if (b < 8'h80) begin
            new_units[n] = make_unit({8'd0, b}, 1'b0);
            n++;
        end else if (b[7:5] == 3'b110 && !fin) begin
            held_phase = u2u_pkg::PH_TWO;
            held_bits  = {5'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110 && !fin) begin
            held_phase = u2u_pkg::PH_THREE;
            held_bits  = {6'd0, b[3:0]};
        end else begin
            new_units[n] = make_unit(u2u_pkg::QMARK, 1'b1);
            n++;
        end
    endtask

    task automatic predict_units(input logic [7:0] b, input logic fin);
        int n;
        n = 0;
        case (held_phase)
            u2u_pkg::PH_IDLE: begin
                open_byte(b, fin, n);
            end
            u2u_pkg::PH_TWO: begin
                new_units[0] = make_unit({5'd0, held_bits[4:0], b[5:0]}, 1'b0);
                n = 1;
                held_phase = u2u_pkg::PH_IDLE;
                held_bits  = '0;
            end
            u2u_pkg::PH_THREE: begin
                if (fin) begin
                    // The held lead is cut off; the final byte is decoded anew.
                    new_units[0] = make_unit(u2u_pkg::QMARK, 1'b1);
                    n = 1;
                    held_phase = u2u_pkg::PH_IDLE;
                    held_bits  = '0;
                    open_byte(b, 1'b1, n);
                end else begin
                    held_bits  = {held_bits[3:0], b[5:0]};
                    held_phase = u2u_pkg::PH_THREE2;
                end
            end
            default: begin
                new_units[0] = make_unit({held_bits, b[5:0]}, 1'b0);
                n = 1;
                held_phase = u2u_pkg::PH_IDLE;
                held_bits  = '0;
            end
        endcase
        if (fin) begin
            held_phase = u2u_pkg::PH_IDLE;
            held_bits  = '0;
        end
        if (n > 0) begin
            new_units[n-1].run_last  = 1'b1;
            new_units[n-1].text_last = fin;
        end
        for (int i = 0; i < n; i++) expected_units.push_back(new_units[i]);
    endtask

    initial begin
        failures    = 0;
        outstanding = 0;
        held_phase  = u2u_pkg::PH_IDLE;
        held_bits   = '0;
    end

    always @(posedge aclk) begin
        u2u_pkg::result_t want;
        if (!aresetn) begin
            held_phase = u2u_pkg::PH_IDLE;
            held_bits  = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_units.size() == 0) begin
                    if (failures < 10)
                        $display("unexpected unit: code=%h tuser=%b tlast=%b",
                                 m_tdata, m_tuser, m_tlast);
                    failures++;
                end else begin
                    want = expected_units.pop_front();
                    if (m_tdata !== want.code_unit || m_tuser[0] !== want.substituted ||
                        m_tuser[1] !== want.run_last || m_tlast !== want.text_last) begin
                        if (failures < 10)
                            $display({"unit mismatch: expected code=%h sub=%b run=%b last=%b,",
                                      " got code=%h sub=%b run=%b last=%b"},
                                     want.code_unit, want.substituted, want.run_last,
                                     want.text_last, m_tdata, m_tuser[0], m_tuser[1],
                                     m_tlast);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready) predict_units(s_tdata, s_tlast);
            outstanding = expected_units.size();
        end
    end

endmodule

[tb/utf8_to_ucs2_decoder_test.sv]
// Testbench top for the UTF-8 to UCS-2 decoder: clock, reset, byte stimulus and verdict.
module utf8_to_ucs2_decoder_test;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_BYTES = 1000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // [7:0] byte_in
    logic        s_tlast;      // text_end
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;      // [15:0] code_unit
    logic [1:0]  m_tuser;      // [0] substituted, [1] run_last
    logic        m_tlast;      // text_last

    int failures;
    int outstanding;
    int idle_cycles;
    int bytes_sent;
    bit send_steady;
    bit recv_steady;

    logic [7:0] text_bytes[$];

    utf8_to_ucs2_decoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    ucs2_unit_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .failures(failures), .outstanding(outstanding)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Ends the run when neither channel moves an item for too long.
    initial idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: a random stall before each item, with steady stretches now and then.
    initial begin : receiver
        int gap;
        int stretch;
        m_tready <= 1'b0;
        stretch = 0;
        @(posedge aclk);
        forever begin
            if (stretch == 0) begin
                stretch     = $urandom_range(10, 60);
                recv_steady = ($urandom_range(0, 3) == 0);
            end
            stretch--;
            gap = recv_steady ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Offers one byte after a random gap and holds it until it is taken. The valid
    // stays high across back-to-back items so it is never lowered and raised in one step.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Holds the input side until every predicted unit has come out. The count is
    // read at the falling edge, away from the checker's updates.
    task automatic drain_units;
        s_tvalid <= 1'b0;
        forever begin
            @(negedge aclk);
            if (outstanding == 0) break;
        end
        @(posedge aclk);
    endtask

    function automatic logic [7:0] cont_byte;
        // Mostly proper continuation bytes; the rest have arbitrary top bits.
        if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Appends one random character, well formed most of the time.
    task automatic append_char;
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: text_bytes.push_back(8'($urandom_range(0, 127)));
            4, 5: begin
                text_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                text_bytes.push_back(cont_byte());
            end
            6, 7: begin
                text_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                text_bytes.push_back(cont_byte());
                text_bytes.push_back(cont_byte());
            end
            8: text_bytes.push_back(8'($urandom_range(0, 255)));
            default: begin
                // A sequence cut short: a lone lead, or a three-byte lead with at most one more byte.
                if ($urandom_range(0, 1) == 0) begin
                    text_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                end else begin
                    text_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                    if ($urandom_range(0, 1) == 0) text_bytes.push_back(cont_byte());
                end
            end
        endcase
    endtask

    // Sends one text of random characters with the end flag on its final byte.
    task automatic send_text;
        int chars;
        text_bytes.delete();
        chars = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(1, 12);
        for (int i = 0; i < chars; i++) append_char();
        for (int i = 0; i < text_bytes.size(); i++)
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    initial begin
        int mark;
        bit mid_drain_done;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= 8'h00;
        s_tlast     <= 1'b0;
        send_steady = 1'b0;
        bytes_sent  = 0;
        mid_drain_done = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: single-byte extremes and stray bytes that become '?'.
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF0, 1'b0);
        // Smallest two-byte, smallest three-byte and largest three-byte sequences.
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // Leads that arrive as the final byte of a text.
        send_byte(8'hC2, 1'b1);
        send_byte(8'hE5, 1'b1);
        // Three-byte sequences cut off after two bytes, final byte plain and not.
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h9F, 1'b1);
        // Complete sequences whose last byte ends the text.
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAA, 1'b1);

        // Random texts, with the input held off once until everything has drained.
        mark = bytes_sent;
        while (bytes_sent - mark < RANDOM_BYTES) begin
            send_steady = ($urandom_range(0, 3) == 0);
            send_text();
            if (!mid_drain_done && bytes_sent - mark >= RANDOM_BYTES / 2) begin
                mid_drain_done = 1'b1;
                drain_units();
            end
        end
        send_steady = 1'b0;

        drain_units();
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        if (failures == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
